// ----- rtl/iwp_pkg.sv -----
// Shared types and constants for the intensity window to palette mapper.
package iwp_pkg;

  localparam int SAMPLE_W = 16;
  localparam int PIX_W    = 8;
  localparam int CNT_W    = 9;
  localparam int QUO_W    = 9;
  localparam int PROD_W   = SAMPLE_W + CNT_W;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 3;

  localparam logic signed [SAMPLE_W-1:0] BLANK_CODE = 16'sh8000;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_MIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_MAX   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PALETTE_CNT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UNDEF_PIX    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_SAT_PIX  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_SAT_PIX = 3'd5;

  typedef enum logic {
    OP_CONVERT = 1'b0,
    OP_LOAD    = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_MAPPED  = 3'd0,
    ST_BLANK   = 3'd1,
    ST_BELOW   = 3'd2,
    ST_ABOVE   = 3'd3,
    ST_INVALID = 3'd4
  } status_t;

  // Item information that travels unchanged alongside the datapath.
  typedef struct packed {
    logic             conv;
    logic             wr;
    status_t          status;
    logic [PIX_W-1:0] alt_pixel;
    logic [7:0]       widx;
    logic [PIX_W-1:0] wdata;
  } side_t;

endpackage

// ----- rtl/iwp_front.sv -----
// Classification, window offset and index scaling stages of the mapper.
module iwp_front #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 up_valid,
  output logic                                 up_ready,
  input  logic                                 operation,
  input  logic signed [iwp_pkg::SAMPLE_W-1:0]  sample,
  input  logic [7:0]                           entry_index,
  input  logic [iwp_pkg::PIX_W-1:0]            entry_value,
  input  logic signed [iwp_pkg::SAMPLE_W-1:0]  window_min,
  input  logic signed [iwp_pkg::SAMPLE_W-1:0]  window_max,
  input  logic [iwp_pkg::CNT_W-1:0]            palette_count,
  input  logic [iwp_pkg::PIX_W-1:0]            undef_pixel,
  input  logic [iwp_pkg::PIX_W-1:0]            low_sat_pixel,
  input  logic [iwp_pkg::PIX_W-1:0]            high_sat_pixel,
  output logic                                 dn_valid,
  input  logic                                 dn_ready,
  output iwp_pkg::side_t                       dn_side,
  output logic [iwp_pkg::PROD_W-1:0]           dn_prod,
  output logic [iwp_pkg::SAMPLE_W-1:0]         dn_den
);

  logic                            a_v_r;
  iwp_pkg::side_t                  a_side_r;
  logic [iwp_pkg::SAMPLE_W-1:0]    a_num_r;
  logic [iwp_pkg::SAMPLE_W-1:0]    a_den_r;
  logic [iwp_pkg::CNT_W-1:0]       a_cm1_r;
  logic                            b_v_r;
  iwp_pkg::side_t                  b_side_r;
  logic [iwp_pkg::PROD_W-1:0]      b_prod_r;
  logic [iwp_pkg::SAMPLE_W-1:0]    b_den_r;

  logic                            en_a;
  logic                            en_b;
  iwp_pkg::side_t                  side_nxt;
  logic signed [iwp_pkg::SAMPLE_W:0] num_wide;
  logic signed [iwp_pkg::SAMPLE_W:0] den_wide;
  logic [iwp_pkg::CNT_W-1:0]       eff_cnt;

  assign en_b     = !b_v_r || dn_ready;
  assign en_a     = !a_v_r || en_b;
  assign up_ready = en_a;

  assign num_wide = 17'(sample) - 17'(window_min);
  assign den_wide = 17'(window_max) - 17'(window_min);

  always_comb begin
    if (palette_count == '0) begin
      eff_cnt = 9'd1;
    end else if (32'(palette_count) > 32'(PALETTE_DEPTH)) begin
      eff_cnt = iwp_pkg::CNT_W'(PALETTE_DEPTH);
    end else begin
      eff_cnt = palette_count;
    end
  end

  always_comb begin
    side_nxt.conv  = (operation == iwp_pkg::OP_CONVERT);
    side_nxt.wr    = (operation == iwp_pkg::OP_LOAD) &&
                     (32'(entry_index) < 32'(PALETTE_DEPTH));
    side_nxt.widx  = entry_index;
    side_nxt.wdata = entry_value;
    priority if (window_max <= window_min) begin
      side_nxt.status    = iwp_pkg::ST_INVALID;
      side_nxt.alt_pixel = '0;
    end else if (sample == iwp_pkg::BLANK_CODE) begin
      side_nxt.status    = iwp_pkg::ST_BLANK;
      side_nxt.alt_pixel = undef_pixel;
    end else if (sample < window_min) begin
      side_nxt.status    = iwp_pkg::ST_BELOW;
      side_nxt.alt_pixel = low_sat_pixel;
    end else if (sample > window_max) begin
      side_nxt.status    = iwp_pkg::ST_ABOVE;
      side_nxt.alt_pixel = high_sat_pixel;
    end else begin
      side_nxt.status    = iwp_pkg::ST_MAPPED;
      side_nxt.alt_pixel = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
    end else begin
      if (en_a) begin
        a_v_r <= up_valid;
      end
      if (en_b) begin
        b_v_r <= a_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      a_side_r <= side_nxt;
      a_num_r  <= num_wide[iwp_pkg::SAMPLE_W-1:0];
      a_den_r  <= den_wide[iwp_pkg::SAMPLE_W-1:0];
      a_cm1_r  <= eff_cnt - 9'd1;
    end
    if (en_b) begin
      b_side_r <= a_side_r;
      b_prod_r <= iwp_pkg::PROD_W'(a_num_r) * iwp_pkg::PROD_W'(a_cm1_r);
      b_den_r  <= a_den_r;
    end
  end

  assign dn_valid = b_v_r;
  assign dn_side  = b_side_r;
  assign dn_prod  = b_prod_r;
  assign dn_den   = b_den_r;

endmodule

// ----- rtl/iwp_div.sv -----
// Pipelined restoring divider that resolves one quotient bit per stage.
module iwp_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          up_valid,
  output logic                          up_ready,
  input  iwp_pkg::side_t                up_side,
  input  logic [iwp_pkg::PROD_W-1:0]    up_prod,
  input  logic [iwp_pkg::SAMPLE_W-1:0]  up_den,
  output logic                          dn_valid,
  input  logic                          dn_ready,
  output iwp_pkg::side_t                dn_side,
  output logic [iwp_pkg::QUO_W-1:0]     dn_quo
);

  localparam int NST = iwp_pkg::QUO_W;

  logic                          v_r    [NST];
  iwp_pkg::side_t                side_r [NST];
  logic [iwp_pkg::PROD_W-1:0]    rem_r  [NST];
  logic [iwp_pkg::SAMPLE_W-1:0]  den_r  [NST];
  logic [iwp_pkg::QUO_W-1:0]     quo_r  [NST];
  logic                          en     [NST+1];

  assign en[NST]  = dn_ready;
  assign up_ready = en[0];

  for (genvar j = 0; j < NST; j++) begin : g_stage
    localparam int K = NST - 1 - j;

    logic                          src_v;
    iwp_pkg::side_t                src_side;
    logic [iwp_pkg::PROD_W-1:0]    src_rem;
    logic [iwp_pkg::SAMPLE_W-1:0]  src_den;
    logic [iwp_pkg::QUO_W-1:0]     src_quo;
    logic [iwp_pkg::PROD_W:0]      trial;
    logic [iwp_pkg::PROD_W-1:0]    rem_nxt;
    logic [iwp_pkg::QUO_W-1:0]     quo_nxt;

    if (j == 0) begin : g_first
      assign src_v    = up_valid;
      assign src_side = up_side;
      assign src_rem  = up_prod;
      assign src_den  = up_den;
      assign src_quo  = '0;
    end else begin : g_rest
      assign src_v    = v_r[j-1];
      assign src_side = side_r[j-1];
      assign src_rem  = rem_r[j-1];
      assign src_den  = den_r[j-1];
      assign src_quo  = quo_r[j-1];
    end

    assign en[j] = !v_r[j] || en[j+1];
    assign trial = {1'b0, src_rem} - ((iwp_pkg::PROD_W+1)'(src_den) << K);

    always_comb begin
      rem_nxt = src_rem;
      quo_nxt = src_quo;
      if (!trial[iwp_pkg::PROD_W]) begin
        rem_nxt    = trial[iwp_pkg::PROD_W-1:0];
        quo_nxt[K] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else if (en[j]) begin
        v_r[j] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en[j]) begin
        side_r[j] <= src_side;
        rem_r[j]  <= rem_nxt;
        den_r[j]  <= src_den;
        quo_r[j]  <= quo_nxt;
      end
    end
  end

  assign dn_valid = v_r[NST-1];
  assign dn_side  = side_r[NST-1];
  assign dn_quo   = quo_r[NST-1];

endmodule

// ----- rtl/iwp_palette.sv -----
// Palette memory with its write path and the registered result stage.
module iwp_palette #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          up_valid,
  output logic                          up_ready,
  input  iwp_pkg::side_t                up_side,
  input  logic [iwp_pkg::QUO_W-1:0]     up_quo,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [iwp_pkg::PIX_W-1:0]     out_pixel,
  output logic [2:0]                    out_status
);

  localparam int ADDR_W = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

  logic [iwp_pkg::PIX_W-1:0]   mem [PALETTE_DEPTH];
  logic                        out_valid_r;
  iwp_pkg::status_t            status_r;
  logic [iwp_pkg::PIX_W-1:0]   alt_r;
  logic [iwp_pkg::PIX_W-1:0]   rd_r;

  logic                        en;
  logic [ADDR_W+8-1:0]         widx_ext;
  logic [ADDR_W+iwp_pkg::QUO_W-1:0] quo_ext;
  logic [ADDR_W-1:0]           waddr;
  logic [ADDR_W-1:0]           raddr;

  assign en       = !out_valid_r || !out_stall;
  assign up_ready = en;

  assign widx_ext = {{ADDR_W{1'b0}}, up_side.widx};
  assign quo_ext  = {{ADDR_W{1'b0}}, up_quo};
  assign waddr    = widx_ext[ADDR_W-1:0];

  always_comb begin
    if (32'(up_quo) > 32'(PALETTE_DEPTH - 1)) begin
      raddr = ADDR_W'(PALETTE_DEPTH - 1);
    end else begin
      raddr = quo_ext[ADDR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= up_valid && up_side.conv;
    end
  end

  always_ff @(posedge clk) begin
    if (en && up_valid && up_side.wr) begin
      mem[waddr] <= up_side.wdata;
    end
    if (en && up_valid && up_side.conv) begin
      rd_r     <= mem[raddr];
      status_r <= up_side.status;
      alt_r    <= up_side.alt_pixel;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = status_r;
  assign out_pixel  = (status_r == iwp_pkg::ST_MAPPED) ? rd_r : alt_r;

endmodule

// ----- rtl/intensity_window_to_palette_core.sv -----
// Top level of the intensity window to palette mapper.
//
// The input channel carries one beat per item: a convert beat (operation 0)
// maps a signed sample to a pixel, a palette beat (operation 1) loads one
// palette entry and produces no result. Each convert beat yields exactly one
// result beat with a pixel and a status, in input order.
// The pipeline has twelve register stages: window classification, index
// scaling, nine quotient stages of the restoring divider and the palette
// read, which is also the result register. One beat can be accepted every
// clock while in_stall is low.
// Palette writes take effect at the read stage, so they keep their order with
// conversions around them.
// Synchronous reset empties the pipeline and loads the register defaults;
// palette contents stay undefined until written.
// When the receiver stalls, the result holds and stages behind it keep
// accepting beats until each holds one, then in_stall rises.
// Configuration writes are allowed only while no beat is in flight.
module intensity_window_to_palette_core #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [iwp_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [iwp_pkg::CFG_W-1:0]            cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_operation,
  input  logic signed [iwp_pkg::SAMPLE_W-1:0]  in_sample,
  input  logic [7:0]                           in_entry_index,
  input  logic [iwp_pkg::PIX_W-1:0]            in_entry_value,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [iwp_pkg::PIX_W-1:0]            out_pixel,
  output logic [2:0]                           out_status
);

  logic signed [iwp_pkg::SAMPLE_W-1:0] window_min_r;
  logic signed [iwp_pkg::SAMPLE_W-1:0] window_max_r;
  logic [iwp_pkg::CNT_W-1:0]           palette_count_r;
  logic [iwp_pkg::PIX_W-1:0]           undef_pixel_r;
  logic [iwp_pkg::PIX_W-1:0]           low_sat_pixel_r;
  logic [iwp_pkg::PIX_W-1:0]           high_sat_pixel_r;

  logic                                fr_ready;
  logic                                fr_valid;
  iwp_pkg::side_t                      fr_side;
  logic [iwp_pkg::PROD_W-1:0]          fr_prod;
  logic [iwp_pkg::SAMPLE_W-1:0]        fr_den;
  logic                                dv_ready;
  logic                                dv_valid;
  iwp_pkg::side_t                      dv_side;
  logic [iwp_pkg::QUO_W-1:0]           dv_quo;
  logic                                pl_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_min_r     <= 16'sd0;
      window_max_r     <= 16'sd255;
      palette_count_r  <= 9'd256;
      undef_pixel_r    <= 8'd0;
      low_sat_pixel_r  <= 8'd0;
      high_sat_pixel_r <= 8'd255;
    end else if (cfg_we) begin
      unique case (cfg_index)
        iwp_pkg::CFG_WINDOW_MIN:   window_min_r     <= cfg_wdata;
        iwp_pkg::CFG_WINDOW_MAX:   window_max_r     <= cfg_wdata;
        iwp_pkg::CFG_PALETTE_CNT:  palette_count_r  <= cfg_wdata[iwp_pkg::CNT_W-1:0];
        iwp_pkg::CFG_UNDEF_PIX:    undef_pixel_r    <= cfg_wdata[iwp_pkg::PIX_W-1:0];
        iwp_pkg::CFG_LOW_SAT_PIX:  low_sat_pixel_r  <= cfg_wdata[iwp_pkg::PIX_W-1:0];
        iwp_pkg::CFG_HIGH_SAT_PIX: high_sat_pixel_r <= cfg_wdata[iwp_pkg::PIX_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign in_stall = !fr_ready;

  iwp_front #(
    .PALETTE_DEPTH(PALETTE_DEPTH)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .up_valid       (in_valid),
    .up_ready       (fr_ready),
    .operation      (in_operation),
    .sample         (in_sample),
    .entry_index    (in_entry_index),
    .entry_value    (in_entry_value),
    .window_min     (window_min_r),
    .window_max     (window_max_r),
    .palette_count  (palette_count_r),
    .undef_pixel    (undef_pixel_r),
    .low_sat_pixel  (low_sat_pixel_r),
    .high_sat_pixel (high_sat_pixel_r),
    .dn_valid       (fr_valid),
    .dn_ready       (dv_ready),
    .dn_side        (fr_side),
    .dn_prod        (fr_prod),
    .dn_den         (fr_den)
  );

  iwp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (fr_valid),
    .up_ready (dv_ready),
    .up_side  (fr_side),
    .up_prod  (fr_prod),
    .up_den   (fr_den),
    .dn_valid (dv_valid),
    .dn_ready (pl_ready),
    .dn_side  (dv_side),
    .dn_quo   (dv_quo)
  );

  iwp_palette #(
    .PALETTE_DEPTH(PALETTE_DEPTH)
  ) u_palette (
    .clk        (clk),
    .rst_n      (rst_n),
    .up_valid   (dv_valid),
    .up_ready   (pl_ready),
    .up_side    (dv_side),
    .up_quo     (dv_quo),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_pixel  (out_pixel),
    .out_status (out_status)
  );

endmodule

// ----- dv/palette_map_check.sv -----
`timescale 1ns / 100ps
// Self-checking monitor that predicts and compares mapped pixels.
module palette_map_check #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [iwp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [iwp_pkg::CFG_W-1:0]           cfg_wdata,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic                                in_operation,
  input  logic signed [iwp_pkg::SAMPLE_W-1:0] in_sample,
  input  logic [7:0]                          in_entry_index,
  input  logic [iwp_pkg::PIX_W-1:0]           in_entry_value,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic [iwp_pkg::PIX_W-1:0]           out_pixel,
  input  logic [2:0]                          out_status,
  output int                                  fail_count,
  output int                                  pending_count,
  output int                                  checked_count
);

  typedef struct packed {
    logic [iwp_pkg::PIX_W-1:0] pixel;
    iwp_pkg::status_t          status;
  } pixel_result_t;

  logic signed [iwp_pkg::SAMPLE_W-1:0] win_lo, win_hi;
  logic [iwp_pkg::CNT_W-1:0]           pal_count;
  logic [iwp_pkg::PIX_W-1:0]           blank_pix, low_pix, high_pix;
  logic [iwp_pkg::PIX_W-1:0]           palette [PALETTE_DEPTH];
  pixel_result_t                       expected_pixels [$];

  function automatic pixel_result_t map_sample(logic signed [iwp_pkg::SAMPLE_W-1:0] s);
    pixel_result_t r;
    int            span_count;
    int            slot;
    r.pixel = '0;
    if (win_hi <= win_lo) begin
      r.status = iwp_pkg::ST_INVALID;
    end else if (s == iwp_pkg::BLANK_CODE) begin
      r.status = iwp_pkg::ST_BLANK;
      r.pixel  = blank_pix;
    end else if (s < win_lo) begin
      r.status = iwp_pkg::ST_BELOW;
      r.pixel  = low_pix;
    end else if (s > win_hi) begin
      r.status = iwp_pkg::ST_ABOVE;
      r.pixel  = high_pix;
    end else begin
      span_count = (pal_count == 0) ? 1 :
                   (pal_count > PALETTE_DEPTH) ? PALETTE_DEPTH : int'(pal_count);
      slot = ((int'(s) - int'(win_lo)) * (span_count - 1)) / (int'(win_hi) - int'(win_lo));
      if (slot >= PALETTE_DEPTH) slot = PALETTE_DEPTH - 1;
      r.status = iwp_pkg::ST_MAPPED;
      r.pixel  = palette[slot];
    end
    return r;
  endfunction

  task automatic note_failure(input string what);
    fail_count++;
    if (fail_count <= 10) $display("mismatch at %0t: %s", $realtime, what);
  endtask

  always @(posedge clk) begin
    pixel_result_t want;
    if (!rst_n) begin
      win_lo    = 16'sd0;
      win_hi    = 16'sd255;
      pal_count = 9'd256;
      blank_pix = 8'd0;
      low_pix   = 8'd0;
      high_pix  = 8'd255;
      for (int i = 0; i < PALETTE_DEPTH; i++) palette[i] = '0;
      expected_pixels.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          iwp_pkg::CFG_WINDOW_MIN:   win_lo    = cfg_wdata[iwp_pkg::SAMPLE_W-1:0];
          iwp_pkg::CFG_WINDOW_MAX:   win_hi    = cfg_wdata[iwp_pkg::SAMPLE_W-1:0];
          iwp_pkg::CFG_PALETTE_CNT:  pal_count = cfg_wdata[iwp_pkg::CNT_W-1:0];
          iwp_pkg::CFG_UNDEF_PIX:    blank_pix = cfg_wdata[iwp_pkg::PIX_W-1:0];
          iwp_pkg::CFG_LOW_SAT_PIX:  low_pix   = cfg_wdata[iwp_pkg::PIX_W-1:0];
          iwp_pkg::CFG_HIGH_SAT_PIX: high_pix  = cfg_wdata[iwp_pkg::PIX_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        checked_count++;
        if (expected_pixels.size() == 0) begin
          note_failure($sformatf("unexpected beat pixel 0x%02h status %0d",
                                 out_pixel, out_status));
        end else begin
          want = expected_pixels.pop_front();
          if (out_pixel !== want.pixel || out_status !== want.status)
            note_failure($sformatf("expected pixel 0x%02h status %0d, got pixel 0x%02h status %0d",
                                   want.pixel, want.status, out_pixel, out_status));
        end
      end
      if (in_valid && !in_stall) begin
        if (in_operation == iwp_pkg::OP_LOAD) begin
          if (int'(in_entry_index) < PALETTE_DEPTH) palette[in_entry_index] = in_entry_value;
        end else begin
          expected_pixels.push_back(map_sample(in_sample));
        end
      end
    end
    pending_count = expected_pixels.size();
  end

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 100ps
// Stimulus and verdict for the intensity window to palette core testbench.
module tb;

  localparam int PALETTE_DEPTH = 256;
  localparam int LATENCY       = 12;

  logic                                clk;
  logic                                rst_n;
  logic                                cfg_we;
  logic [iwp_pkg::CFG_IDX_W-1:0]       cfg_index;
  logic [iwp_pkg::CFG_W-1:0]           cfg_wdata;
  logic                                in_valid;
  logic                                in_stall;
  logic                                in_operation;
  logic signed [iwp_pkg::SAMPLE_W-1:0] in_sample;
  logic [7:0]                          in_entry_index;
  logic [iwp_pkg::PIX_W-1:0]           in_entry_value;
  logic                                out_valid;
  logic                                out_stall;
  logic [iwp_pkg::PIX_W-1:0]           out_pixel;
  logic [2:0]                          out_status;

  int fail_count, pending_count, checked_count;
  int idle_pct, stall_pct;
  int convert_beats, load_beats, window_settings;

  logic signed [iwp_pkg::SAMPLE_W-1:0] cur_min, cur_max;
  logic [iwp_pkg::CNT_W-1:0]           cur_count;
  logic                                entry_loaded [PALETTE_DEPTH];

  int sender_idle [4]   = '{0, 85, 0, 15};
  int receiver_idle [4] = '{0, 0, 85, 15};

  intensity_window_to_palette_core #(.PALETTE_DEPTH(PALETTE_DEPTH)) uut (.*);

  palette_map_check #(.PALETTE_DEPTH(PALETTE_DEPTH)) pixel_check (.*);

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  always @(negedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  initial begin
    #10ms;
    $display("[intensity_window_to_palette_core] ERROR");
    $finish;
  end

  function automatic int slot_of(logic signed [iwp_pkg::SAMPLE_W-1:0] s);
    int span_count;
    if (cur_max <= cur_min || s == iwp_pkg::BLANK_CODE || s < cur_min || s > cur_max)
      return -1;
    span_count = (cur_count == 0) ? 1 :
                 (cur_count > PALETTE_DEPTH) ? PALETTE_DEPTH : int'(cur_count);
    return ((int'(s) - int'(cur_min)) * (span_count - 1)) / (int'(cur_max) - int'(cur_min));
  endfunction

  task automatic push_beat(input iwp_pkg::op_t op, input logic [iwp_pkg::SAMPLE_W-1:0] s,
                           input logic [7:0] idx, input logic [iwp_pkg::PIX_W-1:0] val);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_operation   <= op;
    in_sample      <= s;
    in_entry_index <= idx;
    in_entry_value <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_entry(input logic [7:0] idx, input logic [iwp_pkg::PIX_W-1:0] val);
    entry_loaded[idx] = 1'b1;
    load_beats++;
    push_beat(iwp_pkg::OP_LOAD, 16'($urandom), idx, val);
  endtask

  // Mapped samples only ever read palette entries that were loaded beforehand.
  task automatic send_convert(input logic signed [iwp_pkg::SAMPLE_W-1:0] s);
    int slot;
    slot = slot_of(s);
    if (slot >= 0 && !entry_loaded[slot]) send_entry(slot[7:0], 8'($urandom));
    convert_beats++;
    push_beat(iwp_pkg::OP_CONVERT, s, 8'($urandom), 8'($urandom));
  endtask

  task automatic quiesce();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_count != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [iwp_pkg::CFG_IDX_W-1:0] idx,
                           input logic [iwp_pkg::CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
  endtask

  task automatic load_window(input int lo, input int hi, input int cnt,
                             input int blank, input int low, input int high);
    logic [iwp_pkg::CFG_W-1:0] junk;
    quiesce();
    junk = 16'($urandom);
    write_reg(iwp_pkg::CFG_WINDOW_MIN, lo[15:0]);
    write_reg(iwp_pkg::CFG_WINDOW_MAX, hi[15:0]);
    write_reg(iwp_pkg::CFG_PALETTE_CNT, {junk[15:9], cnt[8:0]});
    write_reg(iwp_pkg::CFG_UNDEF_PIX, {junk[15:8], blank[7:0]});
    write_reg(iwp_pkg::CFG_LOW_SAT_PIX, {junk[7:0], low[7:0]});
    write_reg(iwp_pkg::CFG_HIGH_SAT_PIX, {junk[15:8], high[7:0]});
    cfg_we    <= 1'b0;
    cur_min   = lo[15:0];
    cur_max   = hi[15:0];
    cur_count = cnt[8:0];
    window_settings++;
  endtask

  task automatic pick_window();
    int lo, hi, cnt, a, b;
    a = int'(16'sh0 + $signed(16'($urandom)));
    b = int'(16'sh0 + $signed(16'($urandom)));
    case ($urandom_range(9))
      0: begin
        lo = a;
        hi = a - int'($urandom_range(a + 32768));
      end
      1: begin
        lo = -32768;
        hi = 32767;
      end
      2: begin
        lo = int'($urandom_range(32000)) - 32768;
        hi = lo + int'($urandom_range(20, 1));
      end
      default: begin
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
      end
    endcase
    case ($urandom_range(7))
      0: cnt = 0;
      1: cnt = 1;
      2: cnt = 2;
      3: cnt = 256;
      4: cnt = int'($urandom_range(511, 257));
      default: cnt = int'($urandom_range(256, 1));
    endcase
    load_window(lo, hi, cnt, $urandom_range(255), $urandom_range(255), $urandom_range(255));
  endtask

  task automatic random_beat();
    int r, lo, hi, v;
    lo = int'(cur_min);
    hi = int'(cur_max);
    r  = $urandom_range(99);
    v  = int'($signed(16'($urandom)));
    if (r < 18) begin
      send_entry(8'($urandom), 8'($urandom));
      return;
    end
    if (r < 26) v = -32768;
    else if (r < 40 && lo > -32767) v = -32767 + int'($urandom_range(lo + 32766));
    else if (r < 54 && hi < 32767) v = hi + 1 + int'($urandom_range(32766 - hi));
    else if (r < 60) v = lo;
    else if (r < 66) v = hi;
    else if (r < 94 && hi > lo) v = lo + int'($urandom_range(hi - lo));
    send_convert(v[15:0]);
  endtask

  initial begin
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = iwp_pkg::CFG_WINDOW_MIN;
    cfg_wdata      = '0;
    in_valid       = 1'b0;
    in_operation   = iwp_pkg::OP_CONVERT;
    in_sample      = '0;
    in_entry_index = '0;
    in_entry_value = '0;
    idle_pct       = 0;
    stall_pct      = 0;
    convert_beats  = 0;
    load_beats     = 0;
    window_settings = 0;
    cur_min        = 16'sd0;
    cur_max        = 16'sd255;
    cur_count      = 9'd256;
    for (int i = 0; i < PALETTE_DEPTH; i++) entry_loaded[i] = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_entry(8'd0, 8'h00);
    send_entry(8'd255, 8'hFF);
    send_entry(8'd128, 8'h5A);
    send_convert(16'sd0);
    send_convert(16'sd255);
    send_convert(16'sd128);
    send_convert(iwp_pkg::BLANK_CODE);
    send_convert(-16'sd1);
    send_convert(16'sd256);
    load_window(-32768, 32767, 511, 255, 255, 0);
    send_convert(iwp_pkg::BLANK_CODE);
    send_convert(-16'sd32767);
    send_convert(16'sd32767);
    load_window(100, 100, 256, 17, 34, 51);
    send_convert(iwp_pkg::BLANK_CODE);
    send_convert(16'sd100);
    load_window(32767, -32768, 256, 1, 2, 3);
    send_convert(16'sd0);
    load_window(-10, 10, 0, 200, 201, 202);
    send_convert(16'sd10);
    send_convert(16'sd11);
    send_convert(-16'sd11);
    load_window(0, 1, 2, 0, 255, 128);
    send_convert(16'sd1);
    send_convert(16'sd0);

    for (int ph = 0; ph < 4; ph++) begin
      for (int k = 0; k < 3; k++) begin
        pick_window();
        idle_pct  = sender_idle[ph];
        stall_pct = receiver_idle[ph];
        repeat (42) random_beat();
        idle_pct  = 0;
        stall_pct = 0;
      end
    end

    quiesce();
    $display("Checked %0d result beats from %0d convert and %0d palette beats.",
             checked_count, convert_beats, load_beats);
    $display("Covered %0d window settings with sender gaps and receiver stalls mixed in.",
             window_settings);
    if (fail_count == 0 && pending_count == 0) begin
      $display("[intensity_window_to_palette_core] OK");
    end else begin
      $display("[intensity_window_to_palette_core] ERROR");
    end
    $finish;
  end

endmodule
